### rtl/core/chaskey_block_cipher_core_assert.svh
// ----------------------------------------------------------------------------
// Chaskey block cipher core assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef CHASKEY_BLOCK_CIPHER_CORE_ASSERT_SVH
`define CHASKEY_BLOCK_CIPHER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every rising clock edge outside reset
`define CHBC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset
`define CHBC_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");

`else

`define CHBC_ASSERT(lbl, clk, rst_n, prop)
`define CHBC_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/core/chbc_pkg.sv
// ----------------------------------------------------------------------------
// Chaskey block cipher package
// Shared types, register indexes and rotate helpers.
// ----------------------------------------------------------------------------
package chbc_pkg;

    localparam int WORD_W     = 32;
    localparam int ROUND_W    = 8;
    localparam int CFG_IDX_W  = 3;

    typedef logic [WORD_W-1:0]       word_t;
    typedef logic [3:0][WORD_W-1:0]  block_t;
    typedef logic [ROUND_W-1:0]      round_cnt_t;
    typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;

    localparam cfg_idx_t REG_KEY_ZERO   = 3'd0;
    localparam cfg_idx_t REG_KEY_ONE    = 3'd1;
    localparam cfg_idx_t REG_KEY_TWO    = 3'd2;
    localparam cfg_idx_t REG_KEY_THREE  = 3'd3;
    localparam cfg_idx_t REG_ROUNDS     = 3'd4;

    localparam round_cnt_t ROUNDS_RESET = 8'd16;

    localparam int ROT_A = 5;
    localparam int ROT_B = 16;
    localparam int ROT_C = 8;
    localparam int ROT_D = 13;
    localparam int ROT_E = 7;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    typedef struct packed
    {
        logic load;
        logic step;
        logic finish;
    } seq_ctrl_t;

    function automatic word_t rotl(input word_t w, input int s);
        return (w << s) | (w >> (WORD_W - s));
    endfunction

    function automatic word_t rotr(input word_t w, input int s);
        return (w >> s) | (w << (WORD_W - s));
    endfunction

endpackage

### rtl/core/chbc_round.sv
// ----------------------------------------------------------------------------
// Chaskey round unit
// One forward or inverse ARX permutation round on a 128-bit state.
// ----------------------------------------------------------------------------
module chbc_round
(
    input  chbc_pkg::block_t  state_in,
    input  logic              decrypt,
    output chbc_pkg::block_t  state_out
);

    chbc_pkg::word_t a0, a2, b1, b3, c0, d0, d2, e1, e3, f2;
    chbc_pkg::word_t x1, x2, x3, y0, y2, y3, z0, z1, z2, o0;

    // forward round
    always_comb
    begin
        a0 = state_in[0] + state_in[1];
        b1 = chbc_pkg::rotl(state_in[1], chbc_pkg::ROT_A) ^ a0;
        c0 = chbc_pkg::rotl(a0, chbc_pkg::ROT_B);
        a2 = state_in[2] + state_in[3];
        b3 = chbc_pkg::rotl(state_in[3], chbc_pkg::ROT_C) ^ a2;
        d0 = c0 + b3;
        e3 = chbc_pkg::rotl(b3, chbc_pkg::ROT_D) ^ d0;
        d2 = a2 + b1;
        e1 = chbc_pkg::rotl(b1, chbc_pkg::ROT_E) ^ d2;
        f2 = chbc_pkg::rotl(d2, chbc_pkg::ROT_B);
    end

    // inverse round: undo the forward steps in reverse order
    always_comb
    begin
        x2 = chbc_pkg::rotr(state_in[2], chbc_pkg::ROT_B);
        x1 = chbc_pkg::rotr(state_in[1] ^ x2, chbc_pkg::ROT_E);
        y2 = x2 - x1;
        x3 = chbc_pkg::rotr(state_in[3] ^ state_in[0], chbc_pkg::ROT_D);
        y0 = state_in[0] - x3;
        y3 = chbc_pkg::rotr(x3 ^ y2, chbc_pkg::ROT_C);
        z2 = y2 - y3;
        z0 = chbc_pkg::rotr(y0, chbc_pkg::ROT_B);
        z1 = chbc_pkg::rotr(x1 ^ z0, chbc_pkg::ROT_A);
        o0 = z0 - z1;
    end

    always_comb
    begin
        if (decrypt)
        begin
            state_out[0] = o0;
            state_out[1] = z1;
            state_out[2] = z2;
            state_out[3] = y3;
        end
        else
        begin
            state_out[0] = d0;
            state_out[1] = e1;
            state_out[2] = f2;
            state_out[3] = e3;
        end
    end

endmodule

### rtl/core/chbc_seq.sv
// ----------------------------------------------------------------------------
// Chaskey round sequencer
// Counts rounds and steers load, round and finish of the datapath.
// ----------------------------------------------------------------------------
`include "chaskey_block_cipher_core_assert.svh"

module chbc_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  chbc_pkg::round_cnt_t  round_count,
    output logic                  busy,
    output chbc_pkg::seq_ctrl_t   ctrl
);

    chbc_pkg::seq_state_t  state_reg, state_next;
    chbc_pkg::round_cnt_t  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chbc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        unique case (state_reg)
            chbc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    cnt_next   = round_count;
                    state_next = chbc_pkg::ST_RUN;
                end
            end
            chbc_pkg::ST_RUN:
            begin
                // unwhiten once the last round is done
                if (cnt_reg == '0)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = chbc_pkg::ST_IDLE;
                end
                else
                begin
                    ctrl.step = 1'b1;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
        endcase
    end

    assign busy = (state_reg == chbc_pkg::ST_RUN);

    `CHBC_ASSERT(a_ctrl_onehot, clk, rst_n, $onehot0({ctrl.load, ctrl.step, ctrl.finish}))
    `CHBC_ASSERT(a_load_idle, clk, rst_n, ctrl.load |-> !busy)
    `CHBC_ASSERT(a_finish_idle, clk, rst_n, ctrl.finish |=> !busy)
    `CHBC_ASSERT(a_step_count, clk, rst_n, ctrl.step |=> cnt_reg == $past(cnt_reg) - 8'd1)
    `CHBC_ASSERT_NEVER(a_step_zero, clk, rst_n, ctrl.step && (cnt_reg == '0))

endmodule

### rtl/core/chaskey_block_cipher_core.sv
// ----------------------------------------------------------------------------
// Chaskey block cipher core
// Even-Mansour cipher over the Chaskey permutation, one round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four key words and the round count on the cfg channel
//   (index 0..3 key words, 4 round count, other indexes ignored); cfg_ready
//   is always high. Write configuration only while busy is low.
//   Issue a request by raising start with func (0 encrypt, 1 decrypt) and
//   the four block words; it is taken when start is high and busy is low.
//   The block is whitened at load, passes one round per cycle through a
//   single round unit, and is whitened again in the last cycle.
//   After accept, busy stays high while the round_count rounds run and
//   through the finish state; done is registered from finish, so a
//   new request can be taken in the cycle done is shown.
//   done is high for exactly one cycle with out_word_* valid; the receiver
//   cannot stall, and the words hold until the next result.
//   Reset clears the key to zero, the round count to 16 and aborts any
//   request in flight.
// ----------------------------------------------------------------------------
module chaskey_block_cipher_core
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  chbc_pkg::cfg_idx_t    cfg_index,
    input  chbc_pkg::word_t       cfg_data,

    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  chbc_pkg::word_t       in_word_zero,
    input  chbc_pkg::word_t       in_word_one,
    input  chbc_pkg::word_t       in_word_two,
    input  chbc_pkg::word_t       in_word_three,

    output logic                  done,
    output chbc_pkg::word_t       out_word_zero,
    output chbc_pkg::word_t       out_word_one,
    output chbc_pkg::word_t       out_word_two,
    output chbc_pkg::word_t       out_word_three
);

    chbc_pkg::block_t      key_reg;
    chbc_pkg::round_cnt_t  rounds_reg;
    chbc_pkg::block_t      state_reg;
    chbc_pkg::block_t      round_out;
    chbc_pkg::block_t      in_block;
    chbc_pkg::block_t      out_reg;
    logic                  decrypt_reg;
    logic                  done_reg;
    chbc_pkg::seq_ctrl_t   ctrl;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= chbc_pkg::ROUNDS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                chbc_pkg::REG_KEY_ZERO:  key_reg[0] <= cfg_data;
                chbc_pkg::REG_KEY_ONE:   key_reg[1] <= cfg_data;
                chbc_pkg::REG_KEY_TWO:   key_reg[2] <= cfg_data;
                chbc_pkg::REG_KEY_THREE: key_reg[3] <= cfg_data;
                chbc_pkg::REG_ROUNDS:    rounds_reg <= cfg_data[chbc_pkg::ROUND_W-1:0];
                default:                 ;
            endcase
        end
    end

    chbc_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .round_count (rounds_reg),
        .busy        (busy),
        .ctrl        (ctrl)
    );

    chbc_round u_round
    (
        .state_in  (state_reg),
        .decrypt   (decrypt_reg),
        .state_out (round_out)
    );

    assign in_block[0] = in_word_zero;
    assign in_block[1] = in_word_one;
    assign in_block[2] = in_word_two;
    assign in_block[3] = in_word_three;

    // working state: whiten on load, advance one round per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            state_reg   <= in_block ^ key_reg;
            decrypt_reg <= func;
        end
        else if (ctrl.step)
        begin
            state_reg <= round_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.finish)
        begin
            out_reg <= state_reg ^ key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
        end
    end

    assign done           = done_reg;
    assign out_word_zero  = out_reg[0];
    assign out_word_one   = out_reg[1];
    assign out_word_two   = out_reg[2];
    assign out_word_three = out_reg[3];

endmodule

### tb/chaskey_block_cipher_core_tb.sv
// ----------------------------------------------------------------------------
// Chaskey block cipher core testbench
// Drives blocks through the cipher under several key and round settings,
// predicts each output block in software and compares it word by word.
// ----------------------------------------------------------------------------
module chaskey_block_cipher_core_tb;

    localparam bit OP_ENCRYPT = 1'b0;
    localparam bit OP_DECRYPT = 1'b1;
    localparam chbc_pkg::cfg_idx_t REG_LAST_INDEX = 3'd7;
    localparam int STALL_LIMIT = 3000;

    // Holds the register copy, predicts output blocks and checks them in order
    class chaskey_checker;
        chbc_pkg::word_t key_words[4];
        chbc_pkg::round_cnt_t rounds;
        chbc_pkg::block_t expected_blocks[$];
        int unsigned mismatches;

        function new();
            foreach (key_words[j])
                key_words[j] = '0;
            rounds = chbc_pkg::ROUNDS_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(chbc_pkg::cfg_idx_t idx, chbc_pkg::word_t data);
            if (idx <= chbc_pkg::REG_KEY_THREE)
                key_words[idx[1:0]] = data;
            else if (idx == chbc_pkg::REG_ROUNDS)
                rounds = data[chbc_pkg::ROUND_W-1:0];
        endfunction

        function chbc_pkg::word_t rol32(chbc_pkg::word_t x, int unsigned s);
            return chbc_pkg::word_t'({x, x} >> (chbc_pkg::WORD_W - s));
        endfunction

        function chbc_pkg::word_t ror32(chbc_pkg::word_t x, int unsigned s);
            return chbc_pkg::word_t'({x, x} >> s);
        endfunction

        function chbc_pkg::block_t chaskey_cipher(bit op, chbc_pkg::block_t blk);
            chbc_pkg::word_t w[4];
            chbc_pkg::block_t res;
            for (int j = 0; j < 4; j++)
                w[j] = blk[j] ^ key_words[j];
            for (int r = 0; r < int'(rounds); r++)
            begin
                if (op == OP_DECRYPT)
                begin
                    w[2] = ror32(w[2], chbc_pkg::ROT_B); w[1] ^= w[2];
                    w[1] = ror32(w[1], chbc_pkg::ROT_E);
                    w[2] = w[2] - w[1];
                    w[3] ^= w[0]; w[3] = ror32(w[3], chbc_pkg::ROT_D); w[0] = w[0] - w[3];
                    w[3] ^= w[2]; w[3] = ror32(w[3], chbc_pkg::ROT_C); w[2] = w[2] - w[3];
                    w[0] = ror32(w[0], chbc_pkg::ROT_B); w[1] ^= w[0];
                    w[1] = ror32(w[1], chbc_pkg::ROT_A);
                    w[0] = w[0] - w[1];
                end
                else
                begin
                    w[0] = w[0] + w[1]; w[1] = rol32(w[1], chbc_pkg::ROT_A); w[1] ^= w[0];
                    w[0] = rol32(w[0], chbc_pkg::ROT_B);
                    w[2] = w[2] + w[3]; w[3] = rol32(w[3], chbc_pkg::ROT_C); w[3] ^= w[2];
                    w[0] = w[0] + w[3]; w[3] = rol32(w[3], chbc_pkg::ROT_D); w[3] ^= w[0];
                    w[2] = w[2] + w[1]; w[1] = rol32(w[1], chbc_pkg::ROT_E); w[1] ^= w[2];
                    w[2] = rol32(w[2], chbc_pkg::ROT_B);
                end
            end
            for (int j = 0; j < 4; j++)
                res[j] = w[j] ^ key_words[j];
            return res;
        endfunction

        function chbc_pkg::block_t note_request(bit op, chbc_pkg::block_t blk);
            chbc_pkg::block_t res;
            res = chaskey_cipher(op, blk);
            expected_blocks.push_back(res);
            return res;
        endfunction

        function void check_result(chbc_pkg::block_t got);
            chbc_pkg::block_t want;
            if (expected_blocks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                         $time, got[0], got[1], got[2], got[3]);
                mismatches++;
                return;
            end
            want = expected_blocks.pop_front();
            for (int j = 0; j < 4; j++)
            begin
                if (got[j] !== want[j])
                begin
                    $display("%0t: out_word %0d mismatch, expected %h actual %h",
                             $time, j, want[j], got[j]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    chbc_pkg::cfg_idx_t cfg_index;
    chbc_pkg::word_t cfg_data;
    logic start;
    logic busy;
    logic func;
    chbc_pkg::word_t in_word_zero;
    chbc_pkg::word_t in_word_one;
    chbc_pkg::word_t in_word_two;
    chbc_pkg::word_t in_word_three;
    logic done;
    chbc_pkg::word_t out_word_zero;
    chbc_pkg::word_t out_word_one;
    chbc_pkg::word_t out_word_two;
    chbc_pkg::word_t out_word_three;

    chaskey_checker sb;
    int unsigned stall_cycles = 0;

    chaskey_block_cipher_core dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .in_word_zero   (in_word_zero),
        .in_word_one    (in_word_one),
        .in_word_two    (in_word_two),
        .in_word_three  (in_word_three),
        .done           (done),
        .out_word_zero  (out_word_zero),
        .out_word_one   (out_word_one),
        .out_word_two   (out_word_two),
        .out_word_three (out_word_three)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sample mid-cycle, where every signal is settled
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result({out_word_three, out_word_two, out_word_one, out_word_zero});
    end

    always @(negedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("chaskey_block_cipher_core test failed");
            $finish;
        end
    end

    // Hold the request until busy drops; start stays high for the caller
    task automatic send_block(bit op, chbc_pkg::block_t blk, output chbc_pkg::block_t res);
        start         <= 1'b1;
        func          <= op;
        in_word_zero  <= blk[0];
        in_word_one   <= blk[1];
        in_word_two   <= blk[2];
        in_word_three <= blk[3];
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        res = sb.note_request(op, blk);
    endtask

    task automatic write_reg(chbc_pkg::cfg_idx_t idx, chbc_pkg::word_t data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic idle_gap(int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Drop start and wait for every outstanding block to come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_key(chbc_pkg::word_t k0, chbc_pkg::word_t k1,
                            chbc_pkg::word_t k2, chbc_pkg::word_t k3);
        write_reg(chbc_pkg::REG_KEY_ZERO, k0);
        write_reg(chbc_pkg::REG_KEY_ONE, k1);
        write_reg(chbc_pkg::REG_KEY_TWO, k2);
        write_reg(chbc_pkg::REG_KEY_THREE, k3);
    endtask

    function automatic chbc_pkg::word_t random_word();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic chbc_pkg::block_t random_block();
        chbc_pkg::block_t blk;
        for (int j = 0; j < 4; j++)
            blk[j] = random_word();
        return blk;
    endfunction

    // Mix fresh blocks with round trips that feed a result back the other way
    task automatic run_random(int unsigned count, bit with_gaps);
        chbc_pkg::block_t blk;
        chbc_pkg::block_t res;
        chbc_pkg::block_t last_res;
        bit op;
        bit last_op;
        bit have_last;
        have_last = 1'b0;
        last_op = OP_ENCRYPT;
        last_res = '0;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (have_last && $urandom_range(0, 9) < 3)
            begin
                op = ~last_op;
                blk = last_res;
            end
            else
            begin
                op = 1'($urandom_range(0, 1));
                blk = random_block();
            end
            send_block(op, blk, res);
            last_op = op;
            last_res = res;
            have_last = 1'b1;
            if (with_gaps && $urandom_range(0, 63) == 0)
                drain();
            else if (with_gaps && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        chbc_pkg::block_t res;
        chbc_pkg::word_t data;
        chbc_pkg::round_cnt_t rc;
        int unsigned pick;

        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        func = OP_ENCRYPT;
        in_word_zero = '0;
        in_word_one = '0;
        in_word_two = '0;
        in_word_three = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: zero key, default round count
        send_block(OP_ENCRYPT, '0, res);
        send_block(OP_DECRYPT, '0, res);
        send_block(OP_ENCRYPT, '1, res);
        idle_gap(3);
        send_block(OP_DECRYPT, '1, res);

        // All-ones key, single round given with junk in the upper bits;
        // writes to unused indexes must change nothing
        drain();
        load_key('1, '1, '1, '1);
        for (chbc_pkg::cfg_idx_t idx = chbc_pkg::cfg_idx_t'(chbc_pkg::REG_ROUNDS + 1);
             idx <= REG_LAST_INDEX; idx++)
        begin
            write_reg(idx, 32'h0000_0005);
            if (idx == REG_LAST_INDEX)
                break;
        end
        write_reg(chbc_pkg::REG_ROUNDS, 32'hFFFF_FF01);
        end_writes();
        send_block(OP_ENCRYPT, {32'h89AB_CDEF, 32'h0123_4567, 32'hFEDC_BA98, 32'h7654_3210},
                   res);
        send_block(OP_DECRYPT, random_block(), res);
        send_block(OP_ENCRYPT, '1, res);

        // Zero rounds: output must equal input
        drain();
        load_key(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        write_reg(chbc_pkg::REG_ROUNDS, 32'h0000_0100);
        end_writes();
        send_block(OP_ENCRYPT, random_block(), res);
        send_block(OP_DECRYPT, random_block(), res);

        // Largest round count, then undo it
        drain();
        load_key($urandom, $urandom, $urandom, $urandom);
        write_reg(chbc_pkg::REG_ROUNDS, 32'h0000_00FF);
        end_writes();
        send_block(OP_ENCRYPT, random_block(), res);
        send_block(OP_DECRYPT, res, res);

        drain();
        load_key('0, '0, '0, '0);
        write_reg(chbc_pkg::REG_ROUNDS, 32'd2);
        end_writes();
        send_block(OP_ENCRYPT, {32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF}, res);
        send_block(OP_DECRYPT, {32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0}, res);

        for (int p = 0; p < 13; p++)
        begin
            drain();
            load_key(random_word(), random_word(), random_word(), random_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(chbc_pkg::cfg_idx_t'($urandom_range(chbc_pkg::REG_ROUNDS + 1,
                                                              REG_LAST_INDEX)),
                          $urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0)
                rc = 8'd0;
            else if (pick == 1)
                rc = 8'd255;
            else if (pick == 2)
                rc = 8'd1;
            else if (pick == 3)
                rc = chbc_pkg::ROUNDS_RESET;
            else
                rc = chbc_pkg::round_cnt_t'($urandom_range(2, 24));
            data = $urandom;
            data[chbc_pkg::ROUND_W-1:0] = rc;
            write_reg(chbc_pkg::REG_ROUNDS, data);
            end_writes();
            run_random((rc == 8'd255) ? 6 : 110, $urandom_range(0, 3) != 0);
        end

        // Closing stretch at the default round count, back to back
        drain();
        load_key($urandom, $urandom, $urandom, $urandom);
        write_reg(chbc_pkg::REG_ROUNDS, chbc_pkg::word_t'(chbc_pkg::ROUNDS_RESET));
        end_writes();
        run_random(100, 1'b0);

        drain();
        repeat (int'(sb.rounds) + 4) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("chaskey_block_cipher_core test passed");
        else
            $display("chaskey_block_cipher_core test failed");
        $finish;
    end

endmodule
